// ===== rtl/sdm_pkg.sv =====
// ----------------------------------------------------------------------------
// sdm_pkg: shared types and constants of the signed divider
// Operand codes, special-case codes and the control word carried by the
// divider pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sdm_pkg;

  localparam int DATA_W            = 64;
  localparam int HALF_W            = 32;
  localparam int FRACTION_BITS_DEF = 12;

  localparam logic OP_RAW   = 1'b0;
  localparam logic OP_FIXED = 1'b1;

  localparam logic [1:0] MODE_32_32     = 2'd0;
  localparam logic [1:0] MODE_64_32     = 2'd1;
  localparam logic [1:0] MODE_64_64     = 2'd2;
  localparam logic [1:0] MODE_64_32_ALT = 2'd3;

  localparam logic [DATA_W-1:0] ALL_ONES    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] ZDIV_NEG32  = 64'hFFFF_FFFF_0000_0001;
  localparam logic [DATA_W-1:0] MIN32_EXT   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [DATA_W-1:0] MIN64       = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] ONE64       = 64'h0000_0000_0000_0001;

  typedef enum logic [2:0] {
    SPEC_NONE,
    SPEC_ALL_ONES,
    SPEC_ONE,
    SPEC_ZDIV_NEG32,
    SPEC_MIN32,
    SPEC_MIN64
  } sdm_spec_t;

  typedef struct packed {
    logic      valid;
    logic      neg;
    logic      fixed;
    sdm_spec_t spec;
  } sdm_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sdm_prep.sv =====
// ----------------------------------------------------------------------------
// sdm_prep: operand preparation
// Selects operands by mode, detects the special cases and forms the
// magnitudes that enter the divider cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_prep (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            take,
  input  wire logic                            operation,
  input  wire logic [1:0]                      divide_mode,
  input  wire logic [sdm_pkg::DATA_W-1:0]      dividend,
  input  wire logic [sdm_pkg::DATA_W-1:0]      divisor,
  output sdm_pkg::sdm_ctl_t                    ctl_o,
  output logic      [2*sdm_pkg::DATA_W-1:0]    acc_o,
  output logic      [sdm_pkg::DATA_W-1:0]      ud_o
);

  localparam int DW = sdm_pkg::DATA_W;
  localparam int HW = sdm_pkg::HALF_W;

  logic [DW-1:0] n_sel;
  logic [DW-1:0] d_sel;
  logic          fixed;
  logic          mode32;
  logic          n_neg;
  logic          d_neg;
  sdm_pkg::sdm_spec_t spec;

  sdm_pkg::sdm_ctl_t      ctl_r, ctl_nxt;
  logic [2*DW-1:0]        acc_r, acc_nxt;
  logic [DW-1:0]          ud_r, ud_nxt;

  always_comb begin
    fixed  = (operation == sdm_pkg::OP_FIXED);
    mode32 = 1'b0;
    n_sel  = dividend;
    d_sel  = {{HW{divisor[HW-1]}}, divisor[HW-1:0]};
    if (fixed) begin
      n_sel = {dividend[HW-1:0], {HW{1'b0}}};
    end else begin
      unique case (divide_mode)
        sdm_pkg::MODE_32_32: begin
          mode32 = 1'b1;
          n_sel  = {{HW{dividend[HW-1]}}, dividend[HW-1:0]};
        end
        sdm_pkg::MODE_64_64: begin
          d_sel = divisor;
        end
        sdm_pkg::MODE_64_32, sdm_pkg::MODE_64_32_ALT: begin
          n_sel = dividend;
        end
        default: begin
          n_sel = dividend;
        end
      endcase
    end

    n_neg = n_sel[DW-1];
    d_neg = d_sel[DW-1];

    if (d_sel == '0) begin
      if (mode32) begin
        spec = n_neg ? sdm_pkg::SPEC_ZDIV_NEG32 : sdm_pkg::SPEC_ALL_ONES;
      end else begin
        spec = n_neg ? sdm_pkg::SPEC_ONE : sdm_pkg::SPEC_ALL_ONES;
      end
    end else if (mode32 && n_sel == sdm_pkg::MIN32_EXT && d_sel == sdm_pkg::ALL_ONES) begin
      spec = sdm_pkg::SPEC_MIN32;
    end else if (!mode32 && n_sel == sdm_pkg::MIN64 && d_sel == sdm_pkg::ALL_ONES) begin
      spec = sdm_pkg::SPEC_MIN64;
    end else begin
      spec = sdm_pkg::SPEC_NONE;
    end

    ctl_nxt.valid = take;
    ctl_nxt.neg   = n_neg ^ d_neg;
    ctl_nxt.fixed = fixed;
    ctl_nxt.spec  = spec;
    acc_nxt       = {{DW{1'b0}}, (n_neg ? (DW'(0) - n_sel) : n_sel)};
    ud_nxt        = d_neg ? (DW'(0) - d_sel) : d_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_nxt.valid;
    end
    ctl_r.neg   <= ctl_nxt.neg;
    ctl_r.fixed <= ctl_nxt.fixed;
    ctl_r.spec  <= ctl_nxt.spec;
    acc_r       <= acc_nxt;
    ud_r        <= ud_nxt;
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign ud_o  = ud_r;

endmodule

`default_nettype wire

// ===== rtl/sdm_cell.sv =====
// ----------------------------------------------------------------------------
// sdm_cell: one restoring division step
// Shifts the partial remainder and numerator left by one bit, subtracts the
// divisor where it fits and records one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_cell (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  sdm_pkg::sdm_ctl_t                    ctl_i,
  input  wire logic [2*sdm_pkg::DATA_W-1:0]    acc_i,
  input  wire logic [sdm_pkg::DATA_W-1:0]      ud_i,
  output sdm_pkg::sdm_ctl_t                    ctl_o,
  output logic      [2*sdm_pkg::DATA_W-1:0]    acc_o,
  output logic      [sdm_pkg::DATA_W-1:0]      ud_o
);

  localparam int DW = sdm_pkg::DATA_W;

  logic [2*DW-1:0] sh;
  logic [DW-1:0]   trial;
  logic            fits;

  sdm_pkg::sdm_ctl_t ctl_r;
  logic [2*DW-1:0]   acc_r, acc_nxt;
  logic [DW-1:0]     ud_r;

  always_comb begin
    sh      = {acc_i[2*DW-2:0], 1'b0};
    trial   = sh[2*DW-1:DW];
    fits    = (trial >= ud_i);
    acc_nxt = {(fits ? (trial - ud_i) : trial), sh[DW-1:1], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else begin
      ctl_r.valid <= ctl_i.valid;
    end
    ctl_r.neg   <= ctl_i.neg;
    ctl_r.fixed <= ctl_i.fixed;
    ctl_r.spec  <= ctl_i.spec;
    acc_r       <= acc_nxt;
    ud_r        <= ud_i;
  end

  assign ctl_o = ctl_r;
  assign acc_o = acc_r;
  assign ud_o  = ud_r;

endmodule

`default_nettype wire

// ===== rtl/sdm_post.sv =====
// ----------------------------------------------------------------------------
// sdm_post: result formation
// Restores the quotient sign, applies the special-case values and performs
// the fixed-point rounding, over two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module sdm_post #(
  parameter int FRACTION_BITS = sdm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  sdm_pkg::sdm_ctl_t                 ctl_i,
  input  wire logic [sdm_pkg::DATA_W-1:0]   uq_i,
  output logic                              valid_o,
  output logic      [sdm_pkg::DATA_W-1:0]   quotient_o
);

  localparam int DW = sdm_pkg::DATA_W;
  localparam int HW = sdm_pkg::HALF_W;
  localparam logic [DW-1:0] HALF_LSB = DW'(1) << (HW - 1 - FRACTION_BITS);
  localparam int RSHIFT = HW - FRACTION_BITS;

  logic [DW-1:0] raw_nxt;
  logic [DW-1:0] raw_r;
  logic          v1_r;
  logic          fixed1_r;

  logic [DW-1:0] sum;
  logic [DW-1:0] shifted;
  logic [DW-1:0] q_nxt;
  logic [DW-1:0] q_r;
  logic          v2_r;

  always_comb begin
    case (ctl_i.spec)
      sdm_pkg::SPEC_NONE:       raw_nxt = ctl_i.neg ? (DW'(0) - uq_i) : uq_i;
      sdm_pkg::SPEC_ALL_ONES:   raw_nxt = sdm_pkg::ALL_ONES;
      sdm_pkg::SPEC_ONE:        raw_nxt = sdm_pkg::ONE64;
      sdm_pkg::SPEC_ZDIV_NEG32: raw_nxt = sdm_pkg::ZDIV_NEG32;
      sdm_pkg::SPEC_MIN32:      raw_nxt = sdm_pkg::MIN32_EXT;
      sdm_pkg::SPEC_MIN64:      raw_nxt = sdm_pkg::MIN64;
      default:                  raw_nxt = uq_i;
    endcase
  end

  always_comb begin
    sum     = raw_r + HALF_LSB;
    shifted = sum >> RSHIFT;
    q_nxt   = fixed1_r ? {{HW{shifted[HW-1]}}, shifted[HW-1:0]} : raw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl_i.valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    raw_r    <= raw_nxt;
    fixed1_r <= ctl_i.fixed;
    q_r      <= q_nxt;
  end

  assign valid_o    = v2_r;
  assign quotient_o = q_r;

endmodule

`default_nettype wire

// ===== rtl/signed_divider_with_modes_unit.sv =====
// ----------------------------------------------------------------------------
// signed_divider_with_modes_unit: pipelined signed 64-bit divider
// Integer division in 32/32, 64/32 and 64/64 modes, and a rounded
// fixed-point divide, built as a chain of one-bit restoring cells.
// ----------------------------------------------------------------------------
// A transaction is accepted at each rising edge where start is high and
// busy is low. busy is always low, so a new transaction may be issued in
// every cycle. The operands are in_operation, in_divide_mode, in_dividend
// and in_divisor.
// Each result appears on out_quotient for exactly one cycle, marked by
// out_valid, after its transaction has passed the operand preparation
// register, 64 cells that each resolve one quotient bit, and the
// registers of sign restoration and fixed-point rounding. The cell chain
// sets the throughput of one transaction per cycle.
// Results leave in the order their transactions were accepted.
// The receiver cannot stall, so no result is ever held back.
// A synchronous reset clears every valid bit of the pipeline; transactions
// in flight at reset are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_divider_with_modes_unit #(
  parameter int FRACTION_BITS = sdm_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_operation,
  input  wire logic        [1:0]                 in_divide_mode,
  input  wire logic signed [sdm_pkg::DATA_W-1:0] in_dividend,
  input  wire logic signed [sdm_pkg::DATA_W-1:0] in_divisor,
  output logic                                   out_valid,
  output logic signed      [sdm_pkg::DATA_W-1:0] out_quotient
);

  localparam int DW  = sdm_pkg::DATA_W;
  localparam int LAT = DW + 3;

  sdm_pkg::sdm_ctl_t ctl_c [DW+1];
  logic [2*DW-1:0]   acc_c [DW+1];
  logic [DW-1:0]     ud_c  [DW+1];
  logic [DW-1:0]     quot;

  assign busy = 1'b0;

  sdm_prep u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .take        (start && !busy),
    .operation   (in_operation),
    .divide_mode (in_divide_mode),
    .dividend    (in_dividend),
    .divisor     (in_divisor),
    .ctl_o       (ctl_c[0]),
    .acc_o       (acc_c[0]),
    .ud_o        (ud_c[0])
  );

  for (genvar i = 0; i < DW; i++) begin : g_cell
    sdm_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl_i (ctl_c[i]),
      .acc_i (acc_c[i]),
      .ud_i  (ud_c[i]),
      .ctl_o (ctl_c[i+1]),
      .acc_o (acc_c[i+1]),
      .ud_o  (ud_c[i+1])
    );
  end

  sdm_post #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl_i      (ctl_c[DW]),
    .uq_i       (acc_c[DW][DW-1:0]),
    .valid_o    (out_valid),
    .quotient_o (quot)
  );

  assign out_quotient = quot;

`ifndef SYNTHESIS
  a_result_has_transaction: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("Result strobe without an accepted transaction.");

  a_zero_div_wide: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_operation == sdm_pkg::OP_RAW &&
                        in_divide_mode == sdm_pkg::MODE_64_64 &&
                        in_divisor == '0, LAT))
    |-> (out_quotient == sdm_pkg::ONE64 || out_quotient == sdm_pkg::ALL_ONES))
    else $error("Wide divide by zero gave a value other than 1 or -1.");

  a_fixed_sign_ext: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && in_operation == sdm_pkg::OP_FIXED, LAT))
    |-> (out_quotient[DW-1:DW/2] == {(DW/2){out_quotient[DW/2-1]}}))
    else $error("Fixed-point result is not sign-extended from 32 bits.");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the signed divider with modes
// A queue of division requests feeds a clocked driver that issues one
// transaction per cycle with random gaps. The driver predicts each quotient
// when its transaction is accepted. A clocked monitor compares every
// strobed quotient with the oldest prediction. Directed corner cases come
// first: zero divisors, minimum by minus one, ignored upper bits and
// fixed-point rounding. A long random run follows.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DATA_W       = sdm_pkg::DATA_W;
  localparam int HALF_W       = sdm_pkg::HALF_W;
  localparam int FRAC_BITS    = sdm_pkg::FRACTION_BITS_DEF;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_ITEMS = 1750;

  typedef struct {
    logic              op;
    logic [1:0]        mode;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
    bit                drain;
    bit                burst;
  } div_request_t;

  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              start          = 1'b0;
  logic              in_operation   = sdm_pkg::OP_RAW;
  logic [1:0]        in_divide_mode = sdm_pkg::MODE_32_32;
  logic [DATA_W-1:0] in_dividend    = '0;
  logic [DATA_W-1:0] in_divisor     = '0;
  logic              busy;
  logic              out_valid;
  logic [DATA_W-1:0] out_quotient;

  div_request_t      pending_requests[$];
  logic [DATA_W-1:0] pending_quotients[$];
  div_request_t      next_req;
  logic [DATA_W-1:0] expected_quotient;
  bit                accepted;
  bit                issue;
  int                err_count   = 0;
  int                cycle_count = 0;

  signed_divider_with_modes_unit #(
    .FRACTION_BITS(FRAC_BITS)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_divide_mode(in_divide_mode),
    .in_dividend   (in_dividend),
    .in_divisor    (in_divisor),
    .out_valid     (out_valid),
    .out_quotient  (out_quotient)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [DATA_W-1:0] ext_word(logic [DATA_W-1:0] v);
    return {{HALF_W{v[HALF_W-1]}}, v[HALF_W-1:0]};
  endfunction

  function automatic logic [DATA_W-1:0] trunc_div(logic [DATA_W-1:0] n,
                                                  logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] un;
    logic [DATA_W-1:0] ud;
    logic [DATA_W-1:0] q;
    un = n[DATA_W-1] ? -n : n;
    ud = d[DATA_W-1] ? -d : d;
    q  = un / ud;
    return (n[DATA_W-1] != d[DATA_W-1]) ? -q : q;
  endfunction

  function automatic logic [DATA_W-1:0] wide_quotient(logic [DATA_W-1:0] n,
                                                      logic [DATA_W-1:0] d);
    if (d == '0) return n[DATA_W-1] ? sdm_pkg::ONE64 : sdm_pkg::ALL_ONES;
    if (n == sdm_pkg::MIN64 && d == sdm_pkg::ALL_ONES) return sdm_pkg::MIN64;
    return trunc_div(n, d);
  endfunction

  function automatic logic [DATA_W-1:0] mode_quotient(logic [1:0] mode,
                                                      logic [DATA_W-1:0] n,
                                                      logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] nx;
    logic [DATA_W-1:0] dx;
    nx = ext_word(n);
    dx = ext_word(d);
    case (mode)
      sdm_pkg::MODE_32_32: begin
        if (dx == '0) return nx[DATA_W-1] ? sdm_pkg::ZDIV_NEG32 : sdm_pkg::ALL_ONES;
        if (nx == sdm_pkg::MIN32_EXT && dx == sdm_pkg::ALL_ONES) return sdm_pkg::MIN32_EXT;
        return trunc_div(nx, dx);
      end
      sdm_pkg::MODE_64_64: return wide_quotient(n, d);
      default:             return wide_quotient(n, dx);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] predict_quotient(logic op, logic [1:0] mode,
                                                         logic [DATA_W-1:0] n,
                                                         logic [DATA_W-1:0] d);
    logic [DATA_W-1:0] sum;
    if (op == sdm_pkg::OP_RAW) return mode_quotient(mode, n, d);
    sum = mode_quotient(sdm_pkg::MODE_64_32, {n[HALF_W-1:0], {HALF_W{1'b0}}}, d);
    sum = sum + (sdm_pkg::ONE64 << (31 - FRAC_BITS));
    sum = sum >> (32 - FRAC_BITS);
    return ext_word(sum);
  endfunction

  function automatic logic [DATA_W-1:0] draw_operand();
    logic [DATA_W-1:0] v;
    v = {$urandom(), $urandom()};
    case ($urandom_range(0, 9))
      0: v = '0;
      1: begin
        case ($urandom_range(0, 8))
          0: v = sdm_pkg::ONE64;
          1: v = sdm_pkg::ALL_ONES;
          2: v = sdm_pkg::MIN64;
          3: v = ~sdm_pkg::MIN64;
          4: v = 64'h0000_0000_8000_0000;
          5: v = 64'hFFFF_FFFF_7FFF_FFFF;
          6: v = sdm_pkg::MIN32_EXT;
          7: v = 64'h0000_0000_7FFF_FFFF;
          default: v = {v[DATA_W-1:HALF_W], 32'hFFFF_FFFF};
        endcase
      end
      2: v = {{56{v[7]}}, v[7:0]};
      3: v = {{48{v[15]}}, v[15:0]};
      4: v = ext_word(v);
      5: v = {v[DATA_W-1:HALF_W], {HALF_W{1'b0}}};
      default: ;
    endcase
    return v;
  endfunction

  task automatic add_item(logic op, logic [1:0] mode, logic [DATA_W-1:0] n,
                          logic [DATA_W-1:0] d, bit drain, bit burst);
    div_request_t r;
    r.op    = op;
    r.mode  = mode;
    r.num   = n;
    r.den   = d;
    r.drain = drain;
    r.burst = burst;
    pending_requests.push_back(r);
  endtask

  task automatic report_error(string msg);
    if (err_count < 10) $display("tb_top: mismatch: %s", msg);
    err_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        pending_quotients.push_back(predict_quotient(in_operation, in_divide_mode,
                                                     in_dividend, in_divisor));
      end
      if (accepted || !start) begin
        issue = pending_requests.size() != 0;
        if (issue) begin
          next_req = pending_requests[0];
          if (next_req.drain && pending_quotients.size() != 0) begin
            issue = 1'b0;
          end else if (!next_req.burst && $urandom_range(0, 99) < 11) begin
            issue = 1'b0;
          end
        end
        if (issue) begin
          void'(pending_requests.pop_front());
          in_operation   <= next_req.op;
          in_divide_mode <= next_req.mode;
          in_dividend    <= next_req.num;
          in_divisor     <= next_req.den;
        end
        start <= issue;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_quotients.size() == 0) begin
        report_error($sformatf("unexpected quotient %h", out_quotient));
      end else begin
        expected_quotient = pending_quotients.pop_front();
        if (out_quotient !== expected_quotient) begin
          report_error($sformatf("quotient expected %h got %h",
                                 expected_quotient, out_quotient));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_32_32,
             64'hDEAD_0000_0000_0064, 64'h1234_0000_0000_0007, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_32_32,
             64'h0000_0000_FFFF_FF9C, 64'h0000_0000_0000_0007, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_32_32,
             64'h0000_0000_0000_0005, 64'hFFFF_FFFF_0000_0000, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_32_32, 64'h0000_0000_8000_0001, 64'h0, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_32_32,
             64'h1111_1111_8000_0000, 64'h0000_0000_FFFF_FFFF, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_32,
             ~sdm_pkg::MIN64, 64'hABCD_0000_0000_0003, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_32,
             sdm_pkg::MIN64, 64'h0000_0001_0000_0000, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_32, ~sdm_pkg::MIN64, 64'h0, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_32,
             sdm_pkg::MIN64, 64'h0000_0000_FFFF_FFFF, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_32_ALT,
             sdm_pkg::MIN64, sdm_pkg::ALL_ONES, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_32_ALT,
             -64'd1000000000000, -64'd7, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_64, sdm_pkg::MIN64, sdm_pkg::ALL_ONES, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_64, ~sdm_pkg::MIN64, sdm_pkg::MIN64, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_64,
             sdm_pkg::MIN64, 64'h0000_0001_0000_0000, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_64, 64'h0, 64'h0, 0, 0);
    add_item(sdm_pkg::OP_RAW, sdm_pkg::MODE_64_64, sdm_pkg::MIN64, sdm_pkg::ONE64, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_32_32, 64'd4096, 64'd12288, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_64_32, -64'd6144, 64'd2048, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_64_32, 64'd4096, 64'h0, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_64_32,
             64'hFFFF_FFFF_FFFF_F000, 64'h0000_0005_0000_0000, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_32_32,
             64'h0000_0000_8000_0000, sdm_pkg::ALL_ONES, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_64_64, ~sdm_pkg::MIN64, sdm_pkg::ONE64, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_64_32_ALT,
             64'h0000_0000_7FFF_FFFF, sdm_pkg::ONE64, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_32_32, sdm_pkg::ONE64, 64'd3, 0, 0);
    add_item(sdm_pkg::OP_FIXED, sdm_pkg::MODE_64_64,
             64'd4096, 64'hFFFF_0000_0000_2000, 0, 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      add_item(($urandom_range(0, 3) == 0) ? sdm_pkg::OP_FIXED : sdm_pkg::OP_RAW,
               2'($urandom_range(0, 3)), draw_operand(), draw_operand(),
               (i == 0) || (i == 900), (i >= 1100) && (i < 1400));
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending_requests.size() != 0 || start) @(negedge clk);
    while (pending_quotients.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    err_count += pending_quotients.size();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== signed_divider_with_modes_unit.f =====
rtl/sdm_pkg.sv
rtl/sdm_prep.sv
rtl/sdm_cell.sv
rtl/sdm_post.sv
rtl/signed_divider_with_modes_unit.sv
dv/tb_top.sv
